// File: design/fsrh_pkg.sv
// Shared types and constants for the fan speed ramp block.
package fsrh_pkg;

    localparam int TEMP_W  = 12;
    localparam int TICKS_W = 20;
    localparam int COUNT_W = 21;
    localparam int INDEX_W = 3;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [1:0]               zone_t;

    localparam zone_t ZONE_HOLD = 2'd0;
    localparam zone_t ZONE_HOT  = 2'd1;
    localparam zone_t ZONE_COLD = 2'd2;

    localparam logic [INDEX_W-1:0] REG_ON_THRESHOLD    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_OFF_THRESHOLD   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_RAMP_TICKS      = 3'd2;
    localparam logic [INDEX_W-1:0] REG_START_SPEED     = 3'd3;
    localparam logic [INDEX_W-1:0] REG_SPEED_STEP      = 3'd4;
    localparam logic [INDEX_W-1:0] REG_SPEED_TOLERANCE = 3'd5;

    localparam temp_t              ON_THRESHOLD_RST    = 12'sd640;
    localparam temp_t              OFF_THRESHOLD_RST   = 12'sd560;
    localparam logic [TICKS_W-1:0] RAMP_TICKS_RST      = 20'd60000;
    localparam logic [24:0]        START_SPEED_RST     = 25'd2516582;
    localparam logic [24:0]        SPEED_STEP_RST      = 25'd238;
    localparam logic [24:0]        SPEED_TOLERANCE_RST = 25'd235;

endpackage

// File: design/fsrh_zone_classify.sv
// Classifies three temperature readings into the hot, cold or hold zone.
module fsrh_zone_classify
    import fsrh_pkg::*;
(
    input  temp_t board_temp,
    input  temp_t sensor_a_temp,
    input  temp_t sensor_b_temp,
    input  temp_t on_threshold,
    input  temp_t off_threshold,
    output zone_t zone
);

    logic hot;
    logic cold;

    assign hot  = (board_temp > on_threshold) || (sensor_a_temp > on_threshold)
               || (sensor_b_temp > on_threshold);
    assign cold = (board_temp < off_threshold) && (sensor_a_temp < off_threshold)
               && (sensor_b_temp < off_threshold);

    always_comb
    begin
        if (hot)
        begin
            zone = ZONE_HOT;
        end
        else if (cold)
        begin
            zone = ZONE_COLD;
        end
        else
        begin
            zone = ZONE_HOLD;
        end
    end

endmodule

// File: design/fan_speed_ramp_hysteresis_core.sv
// Top level of the fan speed demand block with hysteresis and timed ramps.
//
// Each input transaction on the s_ group is one control tick carrying three
// signed temperature readings. The first stage registers the zone of the
// tick (hot, cold or between the thresholds). The second stage updates the
// ramp counter and the speed demand and holds them, with the zone, as the
// output transaction on the m_ group, so a tick's result reaches m_tdata once
// the first stage has passed it on and the output is free, and it waits there until taken.
// One tick is accepted per cycle for as long as the
// receiver keeps up; the rate is set by the single state update per cycle.
// When the receiver stalls, the result stays on m_tdata and the first stage
// still takes one further tick, after which s_tready falls until the
// result is taken. The configuration channel is always ready and is meant
// to be written only while no tick is in flight. Reset clears the ramp
// counter and the speed to zero and loads the default register values.
module fan_speed_ramp_hysteresis_core
    import fsrh_pkg::*;
#(
    parameter  int SPEED_FRAC_BITS = 24,
    localparam int SPEED_W         = SPEED_FRAC_BITS + 1,
    localparam int CFG_W           = (SPEED_W > TICKS_W) ? SPEED_W : TICKS_W,
    localparam int OUT_W           = SPEED_W + COUNT_W + 2,
    localparam int OUT_BYTES_W     = ((OUT_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [INDEX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // board_temp [11:0], sensor_a_temp [23:12], sensor_b_temp [35:24], zero fill
    input  logic [39:0]            s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // speed_demand, then ramp_count, then zone, from the lowest bit, zero fill
    output logic [OUT_BYTES_W-1:0] m_tdata
);

    localparam logic [SPEED_W-1:0] FULL_SPEED = SPEED_W'(1) << SPEED_FRAC_BITS;

    temp_t               on_threshold_reg;
    temp_t               off_threshold_reg;
    logic [TICKS_W-1:0]  ramp_ticks_reg;
    logic [SPEED_W-1:0]  start_speed_reg;
    logic [SPEED_W-1:0]  speed_step_reg;
    logic [SPEED_W-1:0]  speed_tolerance_reg;

    zone_t               zone_in;
    zone_t               stage_zone_reg;
    logic                stage_valid_reg;
    zone_t               out_zone_reg;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  counter_reg;
    logic [COUNT_W-1:0]  counter_next;
    logic [SPEED_W-1:0]  speed_reg;
    logic [SPEED_W-1:0]  speed_next;

    logic                out_free;
    logic                advance;
    logic                take_in;

    logic [SPEED_W-1:0]  start_clamped;
    logic [SPEED_W:0]    speed_plus_tol;
    logic [SPEED_W:0]    speed_plus_step;
    logic [SPEED_W-1:0]  speed_up;
    logic [SPEED_W-1:0]  speed_down;
    logic                count_zero;
    logic                count_within;
    logic [COUNT_W-1:0]  count_inc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_threshold_reg    <= ON_THRESHOLD_RST;
            off_threshold_reg   <= OFF_THRESHOLD_RST;
            ramp_ticks_reg      <= RAMP_TICKS_RST;
            start_speed_reg     <= SPEED_W'(START_SPEED_RST);
            speed_step_reg      <= SPEED_W'(SPEED_STEP_RST);
            speed_tolerance_reg <= SPEED_W'(SPEED_TOLERANCE_RST);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ON_THRESHOLD:    on_threshold_reg    <= temp_t'(cfg_data[TEMP_W-1:0]);
                REG_OFF_THRESHOLD:   off_threshold_reg   <= temp_t'(cfg_data[TEMP_W-1:0]);
                REG_RAMP_TICKS:      ramp_ticks_reg      <= cfg_data[TICKS_W-1:0];
                REG_START_SPEED:     start_speed_reg     <= cfg_data[SPEED_W-1:0];
                REG_SPEED_STEP:      speed_step_reg      <= cfg_data[SPEED_W-1:0];
                REG_SPEED_TOLERANCE: speed_tolerance_reg <= cfg_data[SPEED_W-1:0];
                default:             ;
            endcase
        end
    end

    fsrh_zone_classify u_zone (
        .board_temp    (temp_t'(s_tdata[11:0])),
        .sensor_a_temp (temp_t'(s_tdata[23:12])),
        .sensor_b_temp (temp_t'(s_tdata[35:24])),
        .on_threshold  (on_threshold_reg),
        .off_threshold (off_threshold_reg),
        .zone          (zone_in)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = stage_valid_reg && out_free;
    assign s_tready = !stage_valid_reg || out_free;
    assign take_in  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            stage_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            stage_zone_reg <= zone_in;
        end
    end

    assign start_clamped   = (start_speed_reg > FULL_SPEED) ? FULL_SPEED : start_speed_reg;
    assign speed_plus_tol  = {1'b0, speed_reg} + {1'b0, speed_tolerance_reg};
    assign speed_plus_step = {1'b0, speed_reg} + {1'b0, speed_step_reg};
    assign speed_up        = (speed_plus_step > {1'b0, FULL_SPEED}) ? FULL_SPEED
                                                                    : speed_plus_step[SPEED_W-1:0];
    assign speed_down      = (speed_reg < speed_step_reg) ? '0 : (speed_reg - speed_step_reg);
    assign count_zero      = (counter_reg == '0);
    assign count_within    = (counter_reg <= {1'b0, ramp_ticks_reg});
    assign count_inc       = counter_reg + COUNT_W'(1);

    always_comb
    begin
        speed_next   = speed_reg;
        counter_next = counter_reg;
        case (stage_zone_reg)
            ZONE_HOT:
            begin
                if (count_zero && (speed_plus_tol < {1'b0, start_speed_reg}))
                begin
                    speed_next   = start_clamped;
                    counter_next = COUNT_W'(1);
                end
                else if (!count_zero && count_within)
                begin
                    speed_next   = speed_up;
                    counter_next = count_inc;
                end
                else if (!count_within)
                begin
                    speed_next   = FULL_SPEED;
                    counter_next = '0;
                end
                else if (count_zero && (speed_plus_tol > {1'b0, FULL_SPEED}))
                begin
                    speed_next = FULL_SPEED;
                end
            end
            ZONE_COLD:
            begin
                if (count_within && (speed_reg > speed_tolerance_reg))
                begin
                    speed_next   = speed_down;
                    counter_next = count_inc;
                end
                else if (!count_within)
                begin
                    speed_next   = '0;
                    counter_next = '0;
                end
                else if (count_zero && (speed_reg < speed_tolerance_reg))
                begin
                    speed_next = '0;
                end
            end
            default:
            begin
                speed_next   = speed_reg;
                counter_next = counter_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            counter_reg   <= '0;
            speed_reg     <= '0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= stage_valid_reg;
            end
            if (advance)
            begin
                counter_reg <= counter_next;
                speed_reg   <= speed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_zone_reg <= stage_zone_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BYTES_W'({out_zone_reg, counter_reg, speed_reg});

endmodule

// File: bench/tb.sv
// Testbench for the fan speed ramp core: bursty ticks checked against an in-bench ramp model.
`timescale 1ns / 100ps
module tb;
    import fsrh_pkg::*;

    localparam int     FRAC       = 24;
    localparam int     SPD_W      = FRAC + 1;
    localparam int     CFG_DW     = (SPD_W > TICKS_W) ? SPD_W : TICKS_W;
    localparam int     OUT_DW     = ((SPD_W + COUNT_W + 2 + 7) / 8) * 8;
    localparam longint FULL       = longint'(1) << FRAC;
    localparam longint COUNT_MASK = (longint'(1) << COUNT_W) - 1;
    localparam int     IDLE_LIMIT = 2000;

    typedef struct {
        temp_t board;
        temp_t sensor_a;
        temp_t sensor_b;
    } tick_t;

    typedef struct {
        logic [SPD_W-1:0]   speed;
        logic [COUNT_W-1:0] count;
        zone_t              zone;
    } demand_t;

    typedef enum int {GEN_HOT, GEN_COLD, GEN_BETWEEN, GEN_NOISE} gen_kind_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DW-1:0]  cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [OUT_DW-1:0]  m_tdata;

    int     on_thr;
    int     off_thr;
    longint ramp_len;
    longint start_lvl;
    longint step_lvl;
    longint tol_lvl;
    longint fan_count;
    longint fan_speed;

    tick_t       tick_backlog[$];
    demand_t     pending_demands[$];
    tick_t       held_tick;
    int          open_ticks  = 0;
    int          fail_count  = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    logic [15:0] ready_pat   = 16'hFFFF;
    int          pat_left    = 0;
    int          idle_cycles = 0;

    fan_speed_ramp_hysteresis_core #(
        .SPEED_FRAC_BITS(FRAC)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_speed(longint s);
        if (s < 0)
            return 0;
        if (s > FULL)
            return FULL;
        return s;
    endfunction

    function automatic demand_t advance_fan(tick_t t);
        demand_t r;
        logic    hot;
        logic    cold;
        hot  = (t.board > on_thr) || (t.sensor_a > on_thr) || (t.sensor_b > on_thr);
        cold = (t.board < off_thr) && (t.sensor_a < off_thr) && (t.sensor_b < off_thr);
        r.zone = ZONE_HOLD;
        if (hot)
        begin
            r.zone = ZONE_HOT;
            if (fan_count == 0 && fan_speed < start_lvl - tol_lvl)
            begin
                fan_speed = clamp_speed(start_lvl);
                fan_count = 1;
            end
            else if (fan_count > 0 && fan_count <= ramp_len)
            begin
                fan_speed = clamp_speed(fan_speed + step_lvl);
                fan_count = (fan_count + 1) & COUNT_MASK;
            end
            else if (fan_count > ramp_len)
            begin
                fan_speed = FULL;
                fan_count = 0;
            end
            else if (fan_count == 0 && fan_speed > FULL - tol_lvl)
                fan_speed = FULL;
        end
        else if (cold)
        begin
            r.zone = ZONE_COLD;
            if (fan_count <= ramp_len && fan_speed > tol_lvl)
            begin
                fan_speed = clamp_speed(fan_speed - step_lvl);
                fan_count = (fan_count + 1) & COUNT_MASK;
            end
            else if (fan_count > ramp_len)
            begin
                fan_speed = 0;
                fan_count = 0;
            end
            else if (fan_count == 0 && fan_speed < tol_lvl)
                fan_speed = 0;
        end
        r.speed = fan_speed[SPD_W-1:0];
        r.count = fan_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic int pick_temp(int lo, int hi);
        if (lo < -2048)
            lo = -2048;
        if (hi > 2047)
            hi = 2047;
        if (lo > hi)
            return int'($urandom_range(0, 4095)) - 2048;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic longint rand_level(longint floor_lvl);
        longint v;
        case ($urandom_range(0, 5))
            0: v = floor_lvl;
            1: v = FULL;
            2: v = $urandom_range(0, int'(FULL));
            default: v = $urandom_range(0, 1 << $urandom_range(0, FRAC));
        endcase
        return (v < floor_lvl) ? floor_lvl : v;
    endfunction

    task automatic write_reg(logic [INDEX_W-1:0] idx, longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DW-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_setting(int on, int off, int ticks, longint start, longint step,
                                 longint tol);
        write_reg(REG_ON_THRESHOLD, longint'(on));
        write_reg(REG_OFF_THRESHOLD, longint'(off));
        write_reg(REG_RAMP_TICKS, longint'(ticks));
        write_reg(REG_START_SPEED, start);
        write_reg(REG_SPEED_STEP, step);
        write_reg(REG_SPEED_TOLERANCE, tol);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_tick(int b, int a, int s);
        tick_t t;
        t.board    = b[TEMP_W-1:0];
        t.sensor_a = a[TEMP_W-1:0];
        t.sensor_b = s[TEMP_W-1:0];
        open_ticks++;
        tick_backlog.push_back(t);
    endtask

    task automatic push_zone(gen_kind_t kind);
        int v[3];
        int spread;
        int hot_idx;
        spread  = ($urandom_range(0, 3) == 0) ? 4095 : 4;
        hot_idx = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
        begin
            case (kind)
                GEN_HOT:
                    v[i] = (i == hot_idx) ? pick_temp(on_thr + 1, on_thr + spread)
                                          : pick_temp(on_thr - spread, on_thr + spread);
                GEN_COLD:    v[i] = pick_temp(off_thr - spread, off_thr - 1);
                GEN_BETWEEN: v[i] = pick_temp(off_thr, on_thr);
                default:     v[i] = pick_temp(-2048, 2047);
            endcase
        end
        push_tick(v[0], v[1], v[2]);
    endtask

    task automatic drain();
        @(posedge clk);
        while (open_ticks != 0)
            @(posedge clk);
    endtask

    task automatic random_phase();
        int        on;
        int        off;
        int        ticks;
        int        n;
        int        run;
        int        pick;
        gen_kind_t kind;
        on    = ($urandom_range(0, 3) == 0) ? pick_temp(-2048, 2047) : pick_temp(200, 1000);
        off   = ($urandom_range(0, 3) == 0) ? pick_temp(-2048, 2047) : pick_temp(on - 150, on);
        case ($urandom_range(0, 7))
            0: ticks = 1;
            1: ticks = $urandom_range(1, 1048575);
            default: ticks = $urandom_range(1, 24);
        endcase
        write_setting(on, off, ticks, rand_level(0), rand_level(1), rand_level(0));
        n = $urandom_range(100, 140);
        while (n > 0)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 7)
                kind = GEN_HOT;
            else if (pick < 14)
                kind = GEN_COLD;
            else if (pick < 17)
                kind = GEN_BETWEEN;
            else
                kind = GEN_NOISE;
            run = $urandom_range(1, (ticks < 36) ? ticks + 4 : 40);
            for (int i = 0; i < run && n > 0; i++)
            begin
                push_zone(kind);
                n--;
            end
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ON_THRESHOLD:    on_thr    = $signed(cfg_data[TEMP_W-1:0]);
                REG_OFF_THRESHOLD:   off_thr   = $signed(cfg_data[TEMP_W-1:0]);
                REG_RAMP_TICKS:      ramp_len  = cfg_data[TICKS_W-1:0];
                REG_START_SPEED:     start_lvl = cfg_data[24:0];
                REG_SPEED_STEP:      step_lvl  = cfg_data[24:0];
                REG_SPEED_TOLERANCE: tol_lvl   = cfg_data[24:0];
                default: ;
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_demands.push_back(advance_fan(held_tick));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (tick_backlog.size() > 0)
                begin
                    held_tick = tick_backlog.pop_front();
                    s_tdata  <= {4'b0000, held_tick.sensor_b, held_tick.sensor_a,
                                 held_tick.board};
                    s_tvalid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (pat_left == 0)
            begin
                case ($urandom_range(0, 4))
                    0: ready_pat = 16'hFFFF;
                    1: ready_pat = 16'($urandom) | 16'h0001;
                    2: ready_pat = 16'h8888;
                    3: ready_pat = 16'h00FF;
                    default: ready_pat = 16'h0001;
                endcase
                pat_left = $urandom_range(40, 300);
            end
            pat_left--;
            m_tready  <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
        end
    end

    always @(posedge clk)
    begin
        demand_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            open_ticks--;
            if (pending_demands.size() == 0)
            begin
                $error("result transaction with no tick pending: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_demands.pop_front();
                if (m_tdata[SPD_W-1:0] !== want.speed)
                begin
                    $error("speed_demand: expected %0d, got %0d", want.speed,
                           m_tdata[SPD_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[SPD_W+COUNT_W-1:SPD_W] !== want.count)
                begin
                    $error("ramp_count: expected %0d, got %0d", want.count,
                           m_tdata[SPD_W+COUNT_W-1:SPD_W]);
                    fail_count++;
                end
                if (m_tdata[SPD_W+COUNT_W+1:SPD_W+COUNT_W] !== want.zone)
                begin
                    $error("zone: expected %0d, got %0d", want.zone,
                           m_tdata[SPD_W+COUNT_W+1:SPD_W+COUNT_W]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        on_thr    = ON_THRESHOLD_RST;
        off_thr   = OFF_THRESHOLD_RST;
        ramp_len  = RAMP_TICKS_RST;
        start_lvl = START_SPEED_RST;
        step_lvl  = SPEED_STEP_RST;
        tol_lvl   = SPEED_TOLERANCE_RST;
        fan_count = 0;
        fan_speed = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults straight out of reset, with readings on and around each threshold.
        push_tick(-2048, -2048, -2048);
        push_tick(2047, 2047, 2047);
        push_tick(640, 640, 640);
        push_tick(641, 0, 0);
        push_tick(0, 641, 0);
        push_tick(0, 0, 641);
        push_tick(559, 559, 559);
        push_tick(560, 559, 559);
        push_tick(2047, -2048, 2047);
        push_tick(-1, -1, -1);
        push_tick(600, 600, 600);
        drain();

        // Overlapping thresholds, so that hot wins over cold, with a one tick ramp at full steps.
        write_setting(100, 500, 1, FULL, FULL, 0);
        push_tick(200, 200, 200);
        push_tick(200, 200, 200);
        push_tick(200, 200, 200);
        push_tick(-2048, -2048, -2048);
        push_tick(-2048, -2048, -2048);
        push_tick(-2048, -2048, -2048);
        push_tick(100, 100, 100);
        drain();

        // Thresholds at the ends of the range, where neither zone can be reached.
        write_setting(2047, -2048, 1048575, 0, 1, FULL);
        push_tick(2047, 2047, 2047);
        push_tick(-2048, -2048, -2048);
        push_tick(0, 2047, -2048);
        drain();

        write_setting(-2048, 2047, 1, FULL, FULL, 0);
        push_tick(-2048, -2048, -2047);
        push_tick(-2048, -2048, -2048);
        push_tick(-2048, -2048, -2048);
        push_tick(-2047, 2047, 0);
        drain();

        for (int p = 0; p < 12; p++)
            random_phase();

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_demands.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
design/fsrh_pkg.sv
design/fsrh_zone_classify.sv
design/fan_speed_ramp_hysteresis_core.sv
bench/tb.sv
